>>> sv/rlvd_pkg.sv
// Shared types, field positions and helpers for the run/level VLC decoder.
package rlvd_pkg;

	localparam int WINDOW_BITS = 32;
	localparam int LEN_W       = 5;
	localparam int ENTRY_W     = 12;

	// Input tdata layout, lowest bit first
	localparam int IN_WIN_LSB   = 0;
	localparam int IN_NEXT_BIT  = 32;
	localparam int IN_RLEN_LSB  = 33;
	localparam int IN_RFC_LSB   = 38;
	localparam int IN_RCNT_LSB  = 54;
	localparam int IN_RBASE_LSB = 62;
	localparam int IN_EIDX_LSB  = 69;
	localparam int IN_ERUN_LSB  = 76;
	localparam int IN_ELEV_LSB  = 82;
	localparam int IN_TDATA_W   = 88;
	localparam int OUT_TDATA_W  = 24;

	localparam logic [5:0] ESC_PREFIX   = 6'b000001;
	localparam logic [7:0] LB_LONG_POS  = 8'b00000000;
	localparam logic [7:0] LB_LONG_NEG  = 8'b10000000;
	localparam logic [5:0] ESC_USED     = 6'd20;
	localparam logic [5:0] ESC_LONG_USED = 6'd28;

	typedef enum logic [1:0] {
		OP_DECODE = 2'd0,
		OP_ROW    = 2'd1,
		OP_ENTRY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		Q_LOAD = 2'd0,
		Q_ESC  = 2'd1,
		Q_HIT  = 2'd2,
		Q_MISS = 2'd3
	} qkind_t;

	// One command from the classifier to the executor
	typedef struct packed {
		qkind_t      kind;
		logic [5:0]  run;
		logic [8:0]  level;
		logic [5:0]  used;   // escape: bits consumed; hit: code length
		logic [11:0] wdata;  // entry load: {run, level}
		logic        sgn0;   // stream bit right after the code
		logic        sgn1;   // stream bit one further on
		logic        nextc;
	} qcmd_t;

	// Reduce a value below 512 modulo a depth of at least 16 by conditional subtraction.
	function automatic logic [9:0] mod_depth(input logic [9:0] v, input int depth);
		logic [10:0] r;
		logic [10:0] d;
		r = {1'b0, v};
		for (int k = 4; k >= 0; k--) begin
			d = 11'(depth << k);
			if (r >= d)
				r = r - d;
		end
		return r[9:0];
	endfunction

endpackage

>>> sv/rlvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlvd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> sv/rlvd_queue.sv
// Two-entry queue between the classifier and the executor.
module rlvd_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

>>> sv/rlvd_front.sv
// Input stage: holds the length rows, classifies each beat and queues commands.
module rlvd_front import rlvd_pkg::*; #(
	parameter int MAX_CODE_LEN = 16,
	parameter int TABLE_DEPTH  = 128,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_op,
	input  logic [IN_TDATA_W-1:0] in_data,
	input  logic [LEN_W-1:0]      shortest_code,
	input  logic [LEN_W-1:0]      longest_code,
	output logic                  push,
	input  logic                  full,
	output logic [IDX_W-1:0]      push_addr,
	output qcmd_t                 push_cmd
);

	localparam int CMP_W = ((MAX_CODE_LEN > 16) ? MAX_CODE_LEN : 16) + 1;

	logic                  valid_s1;
	logic [1:0]            op_s1;
	logic [IN_TDATA_W-1:0] data_s1;

	logic [WINDOW_BITS-1:0] win;
	logic                   nextc;
	logic [LEN_W-1:0]       row_len;
	logic [15:0]            row_first;
	logic [7:0]             row_cnt;
	logic [6:0]             row_base;
	logic [6:0]             ent_idx;
	logic [5:0]             ent_run;
	logic [5:0]             ent_lev;

	logic [15:0] first_q [1:MAX_CODE_LEN];
	logic [7:0]  count_q [1:MAX_CODE_LEN];
	logic [6:0]  base_q  [1:MAX_CODE_LEN];

	logic                   hit [1:MAX_CODE_LEN];
	logic [7:0]             off [1:MAX_CODE_LEN];
	logic                   sg0 [1:MAX_CODE_LEN];
	logic                   sg1 [1:MAX_CODE_LEN];

	logic [LEN_W-1:0] start_len;
	logic [LEN_W-1:0] stop_len;
	logic             found;
	logic [LEN_W-1:0] sel_len;
	logic [7:0]       sel_off;
	logic [6:0]       sel_base;
	logic             sel_s0;
	logic             sel_s1;
	logic [9:0]       hit_idx;
	logic [9:0]       load_idx;

	logic       esc;
	logic [5:0] esc_run;
	logic [7:0] esc_lb;
	logic [7:0] esc_nx;

	logic needs_push;
	logic consume;
	logic row_we;

	assign win       = data_s1[IN_WIN_LSB +: WINDOW_BITS];
	assign nextc     = data_s1[IN_NEXT_BIT];
	assign row_len   = data_s1[IN_RLEN_LSB +: LEN_W];
	assign row_first = data_s1[IN_RFC_LSB +: 16];
	assign row_cnt   = data_s1[IN_RCNT_LSB +: 8];
	assign row_base  = data_s1[IN_RBASE_LSB +: 7];
	assign ent_idx   = data_s1[IN_EIDX_LSB +: 7];
	assign ent_run   = data_s1[IN_ERUN_LSB +: 6];
	assign ent_lev   = data_s1[IN_ELEV_LSB +: 6];

	assign needs_push = (op_s1 == OP_DECODE) || (op_s1 == OP_ENTRY);
	assign consume    = valid_s1 && (!needs_push || !full);
	assign push       = valid_s1 && needs_push && !full;
	assign in_ready   = !valid_s1 || consume;
	assign row_we     = consume && (op_s1 == OP_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= in_op;
			data_s1 <= in_data;
		end
	end

	assign start_len = (shortest_code == '0) ? LEN_W'(1) : shortest_code;
	assign stop_len  = (longest_code > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
		: longest_code;

	// One compare lane per code length; a row load only lands on its own lane
	for (genvar gl = 1; gl <= MAX_CODE_LEN; gl++) begin : g_lane
		logic [CMP_W-1:0] diff;

		assign diff = CMP_W'(win[WINDOW_BITS-1 -: gl]) - CMP_W'(first_q[gl]);
		assign hit[gl] = (LEN_W'(gl) >= start_len) && (LEN_W'(gl) <= stop_len)
			&& !diff[CMP_W-1] && (diff[CMP_W-2:0] < (CMP_W-1)'(count_q[gl]));
		assign off[gl] = diff[7:0];
		assign sg0[gl] = win[WINDOW_BITS-1-gl];
		assign sg1[gl] = win[WINDOW_BITS-2-gl];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				count_q[gl] <= 8'd0;
			else if (row_we && row_len == LEN_W'(gl))
				count_q[gl] <= row_cnt;
		end

		always_ff @(posedge clk) begin
			if (row_we && row_len == LEN_W'(gl)) begin
				first_q[gl] <= row_first;
				base_q[gl]  <= row_base;
			end
		end
	end

	// Shortest matching length wins
	always_comb begin
		found    = 1'b0;
		sel_len  = '0;
		sel_off  = '0;
		sel_base = '0;
		sel_s0   = 1'b0;
		sel_s1   = 1'b0;
		for (int l = MAX_CODE_LEN; l >= 1; l--) begin
			if (hit[l]) begin
				found    = 1'b1;
				sel_len  = LEN_W'(l);
				sel_off  = off[l];
				sel_base = base_q[l];
				sel_s0   = sg0[l];
				sel_s1   = sg1[l];
			end
		end
	end

	assign hit_idx  = mod_depth(10'(sel_base) + 10'(sel_off), TABLE_DEPTH);
	assign load_idx = mod_depth(10'(ent_idx), TABLE_DEPTH);

	assign esc     = win[WINDOW_BITS-1 -: 6] == ESC_PREFIX;
	assign esc_run = win[WINDOW_BITS-7 -: 6];
	assign esc_lb  = win[WINDOW_BITS-13 -: 8];
	assign esc_nx  = win[WINDOW_BITS-21 -: 8];

	always_comb begin
		push_cmd  = '0;
		push_cmd.kind = Q_MISS;
		push_addr = '0;
		unique case (op_s1)
			OP_DECODE: begin
				push_cmd.nextc = nextc;
				if (esc) begin
					push_cmd.kind = Q_ESC;
					push_cmd.run  = esc_run;
					if (esc_lb == LB_LONG_POS) begin
						push_cmd.level = {1'b0, esc_nx};
						push_cmd.used  = ESC_LONG_USED;
					end else if (esc_lb == LB_LONG_NEG) begin
						push_cmd.level = {1'b1, esc_nx};
						push_cmd.used  = ESC_LONG_USED;
					end else begin
						push_cmd.level = {esc_lb[7], esc_lb};
						push_cmd.used  = ESC_USED;
					end
				end else if (found) begin
					push_cmd.kind = Q_HIT;
					push_cmd.used = {1'b0, sel_len};
					push_cmd.sgn0 = sel_s0;
					push_cmd.sgn1 = sel_s1;
					push_addr     = hit_idx[IDX_W-1:0];
				end
			end
			OP_ENTRY: begin
				push_cmd.kind  = Q_LOAD;
				push_cmd.wdata = {ent_run, ent_lev};
				push_addr      = load_idx[IDX_W-1:0];
			end
			default: begin
				push_cmd.kind = Q_MISS;
			end
		endcase
	end

endmodule

>>> sv/rlvd_back.sv
// Executor: entry RAM writes and reads, result assembly and the output register.
module rlvd_back import rlvd_pkg::*; #(
	parameter int TABLE_DEPTH = 128,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CMD_W = $bits(qcmd_t)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IDX_W+CMD_W-1:0] q_dout,
	input  logic                   q_empty,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_status
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_READ = 2'b10
	} bstate_t;

	bstate_t state_q;
	bstate_t state_d;

	qcmd_t            cmd;
	logic [IDX_W-1:0] addr;

	logic               ram_we;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	logic       nextc_q;
	logic       sgn0_q;
	logic       sgn1_q;
	logic [5:0] len_q;

	logic       out_free;
	logic       load_out;
	logic [5:0] run_d;
	logic [8:0] level_d;
	logic [5:0] used_d;
	logic       status_d;

	logic       out_valid_q;
	logic [5:0] out_run_q;
	logic [8:0] out_level_q;
	logic [5:0] out_used_q;
	logic       out_status_q;

	logic [5:0] e_run;
	logic [5:0] e_mag;
	logic       ext;
	logic       sgn;
	logic [8:0] mag9;

	assign cmd  = qcmd_t'(q_dout[CMD_W-1:0]);
	assign addr = q_dout[CMD_W +: IDX_W];

	rlvd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (cmd.wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || out_ready;

	// The run 0, level 1 entry takes one extra bit after a first coefficient
	assign e_run = ram_rdata[11:6];
	assign e_mag = ram_rdata[5:0];
	assign ext   = (e_run == 6'd0) && (e_mag == 6'd1) && nextc_q;
	assign sgn   = ext ? sgn1_q : sgn0_q;
	assign mag9  = {3'b000, e_mag};

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		load_out = 1'b0;
		run_d    = cmd.run;
		level_d  = cmd.level;
		used_d   = cmd.used;
		status_d = cmd.kind == Q_MISS;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					unique case (cmd.kind)
						Q_LOAD: begin
							ram_we = 1'b1;
							q_pop  = 1'b1;
						end
						Q_HIT: begin
							ram_re  = 1'b1;
							q_pop   = 1'b1;
							state_d = B_READ;
						end
						Q_ESC, Q_MISS: begin
							if (out_free) begin
								load_out = 1'b1;
								q_pop    = 1'b1;
							end
						end
					endcase
				end
			end
			B_READ: begin
				run_d    = e_run;
				level_d  = sgn ? (9'd0 - mag9) : mag9;
				used_d   = len_q + 6'(ext) + 6'd1;
				status_d = 1'b0;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			nextc_q <= cmd.nextc;
			sgn0_q  <= cmd.sgn0;
			sgn1_q  <= cmd.sgn1;
			len_q   <= cmd.used;
		end
		if (load_out) begin
			out_run_q    <= run_d;
			out_level_q  <= level_d;
			out_used_q   <= used_d;
			out_status_q <= status_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = {3'b000, out_used_q, out_level_q, out_run_q};
	assign out_status = out_status_q;

endmodule

>>> sv/dct_run_level_vlc_decoder.sv
// Top level of the DCT run/level VLC decoder: configuration port, classifier, queue, executor.
// Path: a decode beat passes the input register and the queue to the output register for an
// escape or a miss; a table hit also passes the entry RAM read and the B_READ state.
// Throughput: one escape, miss or load per cycle while the queue has room and, for escapes
// and misses, the output is free; a table hit stays in B_READ for the registered RAM read.
// Reset: clears all handshake state, the per-length code counts and sets the search bounds
// to 2 and 16; code rows and entry RAM keep their contents and need no clearing pass.
module dct_run_level_vlc_decoder import rlvd_pkg::*; #(
	parameter int MAX_CODE_LEN = 16,
	parameter int TABLE_DEPTH  = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// bit_window[31:0], next_coefficient[32], row_length[37:33], row_first_code[53:38],
	// row_count[61:54], row_base[68:62], entry_index[75:69], entry_run[81:76],
	// entry_level[87:82]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// run[5:0], level[14:6], bits_used[20:15], zero[23:21]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status[0]
	output logic                   m_axis_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CMD_W = $bits(qcmd_t);

	logic [LEN_W-1:0] shortest_q;
	logic [LEN_W-1:0] longest_q;
	logic             cfg_we;

	logic             push;
	logic             q_full;
	logic [IDX_W-1:0] push_addr;
	qcmd_t            push_cmd;
	logic             q_pop;
	logic             q_empty;
	logic [IDX_W+CMD_W-1:0] q_dout;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {27'd0, longest_q} : {27'd0, shortest_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shortest_q <= LEN_W'(2);
			longest_q  <= LEN_W'(16);
		end else if (cfg_we) begin
			if (paddr[2])
				longest_q <= pwdata[LEN_W-1:0];
			else
				shortest_q <= pwdata[LEN_W-1:0];
		end
	end

	rlvd_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.TABLE_DEPTH  (TABLE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_op         (s_axis_tuser),
		.in_data       (s_axis_tdata),
		.shortest_code (shortest_q),
		.longest_code  (longest_q),
		.push          (push),
		.full          (q_full),
		.push_addr     (push_addr),
		.push_cmd      (push_cmd)
	);

	rlvd_queue #(
		.WIDTH (IDX_W + CMD_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_addr, push_cmd}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	rlvd_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_dout     (q_dout),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_status (m_axis_tuser)
	);

endmodule
